@@ hw/rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache
// Sizes, beat payload structs, chain entry type and cell control bundle.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] COUNT_NEW = CNT_W'(1);

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic        [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic        [KEY_W-1:0] evicted_key;
    } rsp_t;

    typedef struct packed {
        logic        [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
        logic        [CNT_W-1:0] count;
    } entry_t;

    // Broadcast to every cell during the update cycle.
    typedef struct packed {
        logic             upd;
        logic [IDX_W-1:0] p_idx;
        entry_t           mover;
    } cell_ctl_t;

endpackage

@@ hw/rtl/lfu_cell.sv @@
// ----------------------------------------------------------------------------
// lfu_cell: one position of the ordered cache chain
// Holds one entry, matches the lookup key, and on update either keeps its
// entry, takes its left neighbor's entry, or takes the promoted entry.
// ----------------------------------------------------------------------------
module lfu_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lfu_pkg::IDX_W-1:0]      idx,
    input  logic [lfu_pkg::KEY_W-1:0]      lookup_key,
    input  lfu_pkg::cell_ctl_t             ctl,
    input  lfu_pkg::entry_t                left_ent,
    input  logic                           left_le,
    output lfu_pkg::entry_t                ent,
    output logic                           le,
    output logic                           valid,
    output logic                           match
);

    lfu_pkg::entry_t ent_reg, ent_next;
    logic            valid_reg, valid_next;
    logic            at_or_before;
    logic            is_target;
    logic            ins;
    logic            shf;

    assign is_target    = (idx == ctl.p_idx);
    assign at_or_before = (idx <= ctl.p_idx);
    // The target slot always counts as "not ahead" of the mover.
    assign le           = is_target || (ent_reg.count <= ctl.mover.count);
    assign ins          = ctl.upd && at_or_before && le && !left_le;
    assign shf          = ctl.upd && at_or_before && left_le;

    always_comb begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        if (ins) begin
            ent_next = ctl.mover;
        end else if (shf) begin
            ent_next = left_ent;
        end
        if (ctl.upd && is_target) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            ent_reg   <= ent_next;
            valid_reg <= valid_next;
        end
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (ent_reg.key == lookup_key);

endmodule

@@ hw/rtl/lfu_cache_lru_tiebreak.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak: LFU key-value cache with LRU tie-break
// Get/put requests on a sorted chain of cells, one result beat per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry request beats {mode, key, value}; mode
//   selects get or put. m_valid/m_ready/m_payload carry one result beat per
//   request {hit, read_value, evicted, evicted_key}. cfg_we/cfg_wdata write
//   the capacity register (1..ENTRIES in use); write it only while idle.
//   Each request passes through a match cycle in which every cell compares
//   its key in parallel, and an update cycle in which each cell either holds,
//   takes its left neighbor's entry or takes the promoted entry, so the chain
//   stays sorted by use count. The result beat is registered in the update
//   cycle; a new request is taken in the update cycle of the previous one,
//   so consecutive requests overlap. The output register decouples the
//   sides: a result beat waiting on m_ready does not block the next
//   request's match cycle, but that request holds in its update cycle until
//   the output register frees up.
//   Reset (aresetn low, synchronous) empties the cache and sets capacity to
//   16 (clamped to ENTRIES); no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lfu_pkg::req_t               s_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lfu_pkg::rsp_t               m_payload,
    input  logic                        cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]   cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_MATCH  = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    lfu_pkg::req_t                  req_reg;
    logic [lfu_pkg::CAP_W-1:0]      cap_reg;
    logic [lfu_pkg::OCC_W-1:0]      occ_reg, occ_next;

    // Match-cycle results, consumed in the update cycle.
    logic                           upd_reg;
    lfu_pkg::entry_t                mov_reg;
    logic [lfu_pkg::IDX_W-1:0]      p_reg;
    lfu_pkg::rsp_t                  rsp_stage_reg;
    logic [lfu_pkg::OCC_W-1:0]      occ_upd_reg;

    logic                           m_valid_reg;
    lfu_pkg::rsp_t                  m_payload_reg;

    // Chain wiring.
    lfu_pkg::entry_t                cell_ent [lfu_pkg::ENTRIES];
    logic [lfu_pkg::ENTRIES-1:0]    cell_le;
    logic [lfu_pkg::ENTRIES-1:0]    valid_vec;
    logic [lfu_pkg::ENTRIES-1:0]    match_vec;
    lfu_pkg::cell_ctl_t             ctl;

    // Match-cycle combinational results.
    logic                           hit_any;
    lfu_pkg::entry_t                hit_ent;
    logic [lfu_pkg::IDX_W-1:0]      hit_idx;
    logic [lfu_pkg::KEY_W-1:0]      back_key;
    logic [lfu_pkg::CMP_W-1:0]      cap_x, occ_x, eff_cap;
    logic                           full;
    logic                           is_put;
    logic                           evict;
    lfu_pkg::entry_t                mover;
    logic [lfu_pkg::CNT_W-1:0]      hit_count_inc;

    logic                           out_free;
    logic                           do_update;

    assign out_free  = !m_valid_reg || m_ready;
    assign do_update = (state_reg == ST_UPDATE) && out_free;
    assign s_ready   = (state_reg == ST_IDLE) || do_update;

    // ---------------------------------------------------------------- chain
    assign ctl.upd   = do_update && upd_reg;
    assign ctl.p_idx = p_reg;
    assign ctl.mover = mov_reg;

    for (genvar j = 0; j < lfu_pkg::ENTRIES; j++) begin : g_cell
        lfu_pkg::entry_t left_ent;
        logic            left_le;
        if (j == 0) begin : g_head
            assign left_ent = '0;
            assign left_le  = 1'b0;
        end else begin : g_link
            assign left_ent = cell_ent[j-1];
            assign left_le  = cell_le[j-1];
        end
        lfu_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .idx        (lfu_pkg::IDX_W'(j)),
            .lookup_key (req_reg.key),
            .ctl        (ctl),
            .left_ent   (left_ent),
            .left_le    (left_le),
            .ent        (cell_ent[j]),
            .le         (cell_le[j]),
            .valid      (valid_vec[j]),
            .match      (match_vec[j])
        );
    end

    // ---------------------------------------------------------- match cycle
    assign cap_x = lfu_pkg::CMP_W'(cap_reg);
    assign occ_x = lfu_pkg::CMP_W'(occ_reg);

    always_comb begin
        if (cap_x == '0) begin
            eff_cap = lfu_pkg::CMP_W'(1);
        end else if (cap_x > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) begin
            eff_cap = lfu_pkg::CMP_W'(lfu_pkg::ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
    end

    assign full   = (occ_x >= eff_cap) && (occ_x != '0);
    assign is_put = (req_reg.mode == lfu_pkg::MODE_PUT);

    // Keys are unique in the chain, so the match vector is one-hot or empty.
    always_comb begin
        hit_ent  = '0;
        hit_idx  = '0;
        back_key = '0;
        for (int j = 0; j < lfu_pkg::ENTRIES; j++) begin
            if (match_vec[j]) begin
                hit_ent = lfu_pkg::entry_t'(hit_ent | cell_ent[j]);
                hit_idx = hit_idx | lfu_pkg::IDX_W'(j);
            end
            if (lfu_pkg::CMP_W'(j) == occ_x - lfu_pkg::CMP_W'(1)) begin
                back_key = back_key | cell_ent[j].key;
            end
        end
    end

    assign hit_any       = |match_vec;
    assign evict         = !hit_any && is_put && full;
    assign hit_count_inc = (hit_ent.count == lfu_pkg::COUNT_MAX) ?
                           hit_ent.count : hit_ent.count + lfu_pkg::CNT_W'(1);

    always_comb begin
        mover.key = req_reg.key;
        if (hit_any) begin
            mover.value = is_put ? req_reg.value : hit_ent.value;
            mover.count = hit_count_inc;
        end else begin
            mover.value = req_reg.value;
            mover.count = lfu_pkg::COUNT_NEW;
        end
    end

    // ------------------------------------------------------------ registers
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = s_valid ? ST_MATCH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign occ_next = do_update ? occ_upd_reg : occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= lfu_pkg::CAP_RESET;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            // Load the result on update, drop it once taken.
            if (do_update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_payload;
        end
        if (state_reg == ST_MATCH) begin
            upd_reg <= hit_any || is_put;
            mov_reg <= mover;
            if (hit_any) begin
                p_reg <= hit_idx;
            end else if (full) begin
                p_reg <= lfu_pkg::IDX_W'(occ_x - lfu_pkg::CMP_W'(1));
            end else begin
                p_reg <= lfu_pkg::IDX_W'(occ_x);
            end
            occ_upd_reg <= (!hit_any && is_put && !full) ?
                           occ_reg + lfu_pkg::OCC_W'(1) : occ_reg;
            rsp_stage_reg.hit         <= hit_any;
            rsp_stage_reg.read_value  <= (hit_any && !is_put) ? hit_ent.value : '0;
            rsp_stage_reg.evicted     <= evict;
            rsp_stage_reg.evicted_key <= evict ? back_key : '0;
        end
        if (do_update) begin
            m_payload_reg <= rsp_stage_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ----------------------------------------------------------- assertions
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= lfu_pkg::OCC_W'(lfu_pkg::ENTRIES))
        else $error("occupancy beyond chain length");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(occ_reg))
        else $error("valid cells disagree with occupancy");

    a_unique_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATCH) |-> $onehot0(match_vec))
        else $error("key present in more than one cell");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_payload_reg.hit && m_payload_reg.evicted))
        else $error("hit and eviction in one result");

    a_update_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATCH) |=> (state_reg == ST_UPDATE))
        else $error("match cycle not followed by update");

endmodule
